>>> src/bmag_pkg.sv
package bmag_pkg;

   localparam int ADC_W = 13;
   localparam int MV_W = 13;
   localparam int PCT_W = 7;
   localparam int CSR_IDX_W = 1;

   // scaling: code * 800 / 8191, then * 6; 8191 = 2^13 - 1
   localparam int SCALE_NUM = 800;
   localparam int SCALE_SHIFT = 13;
   localparam int SCALE_MUL = 6;
   localparam int SCALE_PROD_W = 23;

   localparam int PCT_TOP = 99;
   localparam int PCT_PROD_W = 20;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_EMPTY_LEVEL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_LEVEL = 1'd1;

   localparam logic [MV_W-1:0] EMPTY_LEVEL_RESET = 13'd3300;
   localparam logic [MV_W-1:0] FULL_LEVEL_RESET = 13'd4200;

   typedef struct packed {
      logic clear;
      logic load;
      logic scale;
      logic update;
      logic avg_start;
      logic avg_take;
      logic pct_prep;
      logic pct_start;
      logic pct_take;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic pct_direct;
      logic out_free;
   } dp_sts_type;

endpackage

>>> src/bmag_ram.sv
module bmag_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 100
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/bmag_div.sv
module bmag_div #(
   parameter int N = 20,
   parameter int M = 13
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [M-1:0] divisor,
   output logic         done,
   output logic [N-1:0] quotient
);

   localparam int CNT_W = $clog2(N + 1);

   logic [M-1:0]     rem_ff, rem_in;
   logic [N-1:0]     quo_ff, quo_in;
   logic [M-1:0]     div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [M:0]       shifted;
   logic [M:0]       diff;
   logic             ge;

   // restoring division, one quotient bit a cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[N-1]};
      diff = shifted - {1'b0, div_ff};
      ge = shifted >= {1'b0, div_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
         cnt_in = CNT_W'(N);
      end else if (cnt_ff != '0) begin
         rem_in = ge ? diff[M-1:0] : shifted[M-1:0];
         quo_in = {quo_ff[N-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

>>> src/bmag_dp.sv
module bmag_dp #(
   parameter int WINDOW = 100
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bmag_pkg::dp_cmd_type                 cmd,
   output bmag_pkg::dp_sts_type                 sts,
   input  logic [bmag_pkg::ADC_W-1:0]           adc_code,
   input  logic                                 csr_wr_en,
   input  logic [bmag_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bmag_pkg::MV_W-1:0]            csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bmag_pkg::MV_W-1:0]            rsp_average_mv,
   output logic [bmag_pkg::PCT_W-1:0]           rsp_charge_percent
);

   localparam int MV_W = bmag_pkg::MV_W;
   localparam int PCT_W = bmag_pkg::PCT_W;
   localparam int SP_W = bmag_pkg::SCALE_PROD_W;
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = $clog2(4800 * WINDOW + 1);
   localparam int DIV_N = (SUM_W > bmag_pkg::PCT_PROD_W) ? SUM_W : bmag_pkg::PCT_PROD_W;
   localparam int DIV_M = (CNT_W > MV_W) ? CNT_W : MV_W;

   logic [SP_W-1:0]   scale_prod_ff, scale_prod_in;
   logic [MV_W-1:0]   mv_ff, mv_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [MV_W-1:0]   avg_ff, avg_in;
   logic [PCT_W-1:0]  pct_ff, pct_in;
   logic [bmag_pkg::PCT_PROD_W-1:0] pct_prod_ff, pct_prod_in;
   logic [MV_W-1:0]   empty_ff, empty_in;
   logic [MV_W-1:0]   full_ff, full_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MV_W-1:0]   rsp_avg_ff, rsp_avg_in;
   logic [PCT_W-1:0]  rsp_pct_ff, rsp_pct_in;

   logic [SP_W:0]     scale_sum;
   logic [SP_W-bmag_pkg::SCALE_SHIFT:0] scale_q;
   logic [MV_W-1:0]   old_mv;
   logic [MV_W-1:0]   ram_rdata;
   logic              below_empty;
   logic              above_full;
   logic [DIV_N-1:0]  div_dividend;
   logic [DIV_M-1:0]  div_divisor;
   logic [DIV_N-1:0]  div_quotient;
   logic              div_done;

   bmag_ram #(
      .WIDTH(MV_W),
      .DEPTH(WINDOW)
   ) u_ring (
      .clock  (clock),
      .wr_en  (cmd.update),
      .wr_addr(slot_ff),
      .wr_data(mv_ff),
      .rd_en  (cmd.load),
      .rd_addr(slot_ff),
      .rd_data(ram_rdata)
   );

   bmag_div #(
      .N(DIV_N),
      .M(DIV_M)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.avg_start | cmd.pct_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quotient)
   );

   always_comb begin
      // divide by 2^13-1: (x + (x >> 13) + 1) >> 13
      scale_sum = {1'b0, scale_prod_ff} + (SP_W + 1)'(scale_prod_ff >> bmag_pkg::SCALE_SHIFT)
                  + (SP_W + 1)'(1);
      scale_q = scale_sum[SP_W:bmag_pkg::SCALE_SHIFT];
      // slots not yet written since the last clear read as zero
      old_mv = (count_ff == CNT_W'(WINDOW)) ? ram_rdata : '0;
      below_empty = avg_ff <= empty_ff;
      above_full = avg_ff >= full_ff;
      if (cmd.avg_start) begin
         div_dividend = DIV_N'(sum_ff);
         div_divisor = DIV_M'(count_ff);
      end else begin
         div_dividend = DIV_N'(pct_prod_ff);
         div_divisor = DIV_M'(full_ff - empty_ff);
      end
   end

   always_comb begin
      scale_prod_in = scale_prod_ff;
      mv_in = mv_ff;
      sum_in = sum_ff;
      slot_in = slot_ff;
      count_in = count_ff;
      avg_in = avg_ff;
      pct_in = pct_ff;
      pct_prod_in = pct_prod_ff;
      empty_in = empty_ff;
      full_in = full_ff;
      rsp_avg_in = rsp_avg_ff;
      rsp_pct_in = rsp_pct_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_wr_en) begin
         case (csr_index)
            bmag_pkg::REG_EMPTY_LEVEL: empty_in = csr_wdata;
            bmag_pkg::REG_FULL_LEVEL:  full_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.clear) begin
         sum_in = '0;
         slot_in = '0;
         count_in = '0;
      end
      if (cmd.load) begin
         scale_prod_in = SP_W'(adc_code) * SP_W'(bmag_pkg::SCALE_NUM);
      end
      if (cmd.scale) begin
         mv_in = MV_W'(scale_q * MV_W'(bmag_pkg::SCALE_MUL));
      end
      if (cmd.update) begin
         sum_in = sum_ff - SUM_W'(old_mv) + SUM_W'(mv_ff);
         slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         if (count_ff != CNT_W'(WINDOW)) begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.avg_take) begin
         avg_in = div_quotient[MV_W-1:0];
      end
      if (cmd.pct_prep) begin
         pct_in = below_empty ? '0 : PCT_W'(bmag_pkg::PCT_TOP);
         pct_prod_in = bmag_pkg::PCT_PROD_W'(avg_ff - empty_ff)
                       * bmag_pkg::PCT_PROD_W'(bmag_pkg::PCT_TOP);
      end
      if (cmd.pct_take) begin
         pct_in = div_quotient[PCT_W-1:0];
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_avg_in = avg_ff;
         rsp_pct_in = pct_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         slot_ff <= '0;
         count_ff <= '0;
         empty_ff <= bmag_pkg::EMPTY_LEVEL_RESET;
         full_ff <= bmag_pkg::FULL_LEVEL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         slot_ff <= slot_in;
         count_ff <= count_in;
         empty_ff <= empty_in;
         full_ff <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scale_prod_ff <= scale_prod_in;
      mv_ff <= mv_in;
      avg_ff <= avg_in;
      pct_ff <= pct_in;
      pct_prod_ff <= pct_prod_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_pct_ff <= rsp_pct_in;
   end

   assign sts.div_done = div_done;
   assign sts.pct_direct = below_empty || above_full;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_average_mv = rsp_avg_ff;
   assign rsp_charge_percent = rsp_pct_ff;

endmodule

>>> src/bmag_ctrl.sv
module bmag_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   output logic                 req_stall,
   input  bmag_pkg::dp_sts_type sts,
   output bmag_pkg::dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_UPDATE,
      ST_AVG_START,
      ST_AVG,
      ST_PCT_PREP,
      ST_PCT_START,
      ST_PCT,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == bmag_pkg::CMD_CLEAR) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = ST_AVG_START;
         end
         ST_AVG_START: begin
            cmd.avg_start = 1'b1;
            state_in = ST_AVG;
         end
         ST_AVG: begin
            if (sts.div_done) begin
               cmd.avg_take = 1'b1;
               state_in = ST_PCT_PREP;
            end
         end
         ST_PCT_PREP: begin
            cmd.pct_prep = 1'b1;
            state_in = sts.pct_direct ? ST_OUT : ST_PCT_START;
         end
         ST_PCT_START: begin
            cmd.pct_start = 1'b1;
            state_in = ST_PCT;
         end
         ST_PCT: begin
            if (sts.div_done) begin
               cmd.pct_take = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

>>> src/battery_moving_average_gauge_unit.sv
// Battery gauge: each sample item scales a 13-bit converter code to millivolts
// (code * 800 / 8191, then * 6), puts it into a ring of WINDOW samples with a
// running sum, and returns the average over the samples taken so far (at most
// WINDOW) and a 0..99 charge percent between the empty and full levels. A clear
// item empties the window and returns nothing. A sample item uses the shared
// one-bit-per-cycle divider, N = max(sum width, 20) bits wide (20 with WINDOW
// = 100), for the average and, unless the percent clamps to 0 or 99, for the
// percent. One item is in work at a time; a finished result waits in an output
// register while the next item is taken.
module battery_moving_average_gauge_unit #(
   parameter int WINDOW = 100
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [bmag_pkg::ADC_W-1:0]        req_adc_code,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bmag_pkg::MV_W-1:0]         rsp_average_mv,
   output logic [bmag_pkg::PCT_W-1:0]        rsp_charge_percent,
   input  logic                              csr_wr_en,
   input  logic [bmag_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bmag_pkg::MV_W-1:0]         csr_wdata
);

   bmag_pkg::dp_cmd_type cmd;
   bmag_pkg::dp_sts_type sts;

   bmag_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_command(req_command),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   bmag_dp #(
      .WINDOW(WINDOW)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .adc_code          (req_adc_code),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average_mv    (rsp_average_mv),
      .rsp_charge_percent(rsp_charge_percent)
   );

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded over an unread result");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("loaded result not shown");

   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command == bmag_pkg::CMD_SAMPLE) |=> req_stall)
      else $error("sample item not held off the input");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_stall && !cmd.update)
      else $error("clear outside idle");

endmodule
